// File: hdl/hs_pkg.sv
// hs_pkg: shared widths, cordic constants, state types and command struct
// for the heading smoother; no dependencies
package hs_pkg;

    localparam int POSITION_BITS = 32;
    localparam int ANGLE_BITS    = 16;
    localparam int DIFF_BITS     = POSITION_BITS + 1;
    // cordic datapath: normalized magnitude sits below 2^41, gain and growth add two bits
    localparam int CW            = (DIFF_BITS + 2 > 45) ? DIFF_BITS + 2 : 45;
    localparam int ZW            = 32;
    localparam int CORDIC_STEPS  = 20;
    localparam int ITER_BITS     = $clog2(CORDIC_STEPS);
    localparam int SM_BITS       = 18;
    localparam int ALPHA_BITS    = 16;
    localparam int MUL_BITS      = ALPHA_BITS + 2;
    localparam int PROD_BITS     = MUL_BITS + SM_BITS;
    localparam int ACC_BITS      = PROD_BITS + 2;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd6554;
    localparam logic signed [CW-1:0]  GAIN_Q30    = CW'(652032874);

    typedef enum logic {
        MODE_VECTOR,
        MODE_ROTATE
    } cordic_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_cmd_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_NORM,
        CS_ITER,
        CS_DONE
    } cordic_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_GO,
        ST_SEED_WAIT,
        ST_DIR_GO,
        ST_DIR_WAIT,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_MAC_CN,
        ST_MAC_CO,
        ST_MAC_SN,
        ST_MAC_SO,
        ST_MAC_END,
        ST_FIX_GO,
        ST_FIX_WAIT,
        ST_RESULT
    } ctrl_state_t;

    // arctangent of 2^-i as a fraction of a turn, 2^32 per turn
    function automatic logic [ZW-1:0] atan_lookup(input logic [ITER_BITS-1:0] idx);
        logic [ZW-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/heading_smoother.sv
// heading_smoother: sequencer, blend multiplier and smoothed state around
// the shared cordic engine; uses hs_pkg and hs_cordic
//
// sequence: a pass-through request goes straight to the result; a seeded first
// point takes one rotation cordic run; a smoothed point takes a vectoring run,
// a rotation run, 4 multiplies and a second vectoring run, each vectoring run
// normalizing first and skipping normalization and micro-rotations on a zero input
// throughput: one request at a time; a new request is taken while the
// previous result waits at the output register
// reset: async active low, blend weight 6554, cos one, sin zero, run invalid
module heading_smoother (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    first_point,
    input  logic                                    heading_valid,
    input  logic signed [hs_pkg::POSITION_BITS-1:0] pos_x,
    input  logic signed [hs_pkg::POSITION_BITS-1:0] pos_y,
    input  logic signed [hs_pkg::ANGLE_BITS-1:0]    start_heading,
    input  logic signed [hs_pkg::ANGLE_BITS-1:0]    original_yaw,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [hs_pkg::ANGLE_BITS-1:0]    yaw,
    input  logic                                    cfg_wr_en,
    input  logic [hs_pkg::ALPHA_BITS-1:0]           cfg_wr_data
);
    import hs_pkg::*;

    localparam logic signed [SM_BITS-1:0]  SM_ONE  = SM_BITS'(65536);
    localparam logic signed [ACC_BITS-1:0] RND_MAC = ACC_BITS'(32768);
    localparam logic signed [ZW-1:0]       RND_OUT = ZW'(1) << (ZW - 1 - ANGLE_BITS);

    ctrl_state_t                 state_reg, state_next;
    logic [ALPHA_BITS-1:0]       alpha_reg;
    logic signed [POSITION_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [DIFF_BITS-1:0] dx_reg, dy_reg;
    logic signed [ANGLE_BITS-1:0] ih_reg, res_reg, yaw_reg;
    logic signed [SM_BITS-1:0]   smooth_cos_reg, smooth_sin_reg, cn_reg, sn_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic                        run_valid_reg, out_valid_reg;

    cordic_cmd_t                 cmd;
    logic signed [CW-1:0]        cx, cy;
    logic signed [ZW-1:0]        cz, c_z_out, z_round;
    logic signed [SM_BITS-1:0]   c_cos, c_sin;
    logic                        c_done;

    logic                        accept, out_free;
    logic signed [MUL_BITS-1:0]  mul_a, beta;
    logic signed [SM_BITS-1:0]   mul_b;
    logic signed [PROD_BITS-1:0] prod;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // saturated q1.16 value of the rounded accumulator
    function automatic logic signed [SM_BITS-1:0] sat_acc(input logic signed [ACC_BITS-1:0] a);
        logic signed [ACC_BITS-17:0] r;
        logic signed [SM_BITS-1:0]   v;
        r = (ACC_BITS-16)'(a >>> 16);
        if (r > (ACC_BITS-16)'(131071))
            v = SM_BITS'(131071);
        else if (r < -(ACC_BITS-16)'(131072))
            v = -SM_BITS'(131072);
        else
            v = r[SM_BITS-1:0];
        return v;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (first_point)
                        state_next = heading_valid ? ST_SEED_GO : ST_RESULT;
                    else
                        state_next = run_valid_reg ? ST_DIR_GO : ST_RESULT;
                end
            end
            ST_SEED_GO:   state_next = ST_SEED_WAIT;
            ST_SEED_WAIT: if (c_done) state_next = ST_RESULT;
            ST_DIR_GO:    state_next = ST_DIR_WAIT;
            ST_DIR_WAIT:  if (c_done) state_next = ST_ROT_GO;
            ST_ROT_GO:    state_next = ST_ROT_WAIT;
            ST_ROT_WAIT:  if (c_done) state_next = ST_MAC_CN;
            ST_MAC_CN:    state_next = ST_MAC_CO;
            ST_MAC_CO:    state_next = ST_MAC_SN;
            ST_MAC_SN:    state_next = ST_MAC_SO;
            ST_MAC_SO:    state_next = ST_MAC_END;
            ST_MAC_END:   state_next = ST_FIX_GO;
            ST_FIX_GO:    state_next = ST_FIX_WAIT;
            ST_FIX_WAIT:  if (c_done) state_next = ST_RESULT;
            ST_RESULT:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs: cordic command, operands and multiplier selects
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        cmd.start = 1'b0;
        cmd.mode  = MODE_ROTATE;
        cx        = '0;
        cy        = '0;
        cz        = '0;
        beta      = MUL_BITS'(SM_ONE) - MUL_BITS'(alpha_reg);
        mul_a     = MUL_BITS'(alpha_reg);
        mul_b     = cn_reg;
        case (state_reg)
            ST_SEED_GO:
            begin
                cmd.start = 1'b1;
                cz        = {ih_reg, {(ZW - ANGLE_BITS){1'b0}}};
            end
            ST_DIR_GO:
            begin
                cmd.start = 1'b1;
                cmd.mode  = MODE_VECTOR;
                cx        = CW'(dx_reg);
                cy        = CW'(dy_reg);
            end
            ST_ROT_GO:
            begin
                cmd.start = 1'b1;
                cz        = c_z_out;
            end
            ST_FIX_GO:
            begin
                cmd.start = 1'b1;
                cmd.mode  = MODE_VECTOR;
                cx        = CW'(smooth_cos_reg);
                cy        = CW'(smooth_sin_reg);
            end
            ST_MAC_CO:
            begin
                mul_a = beta;
                mul_b = smooth_cos_reg;
            end
            ST_MAC_SN:
            begin
                mul_b = sn_reg;
            end
            ST_MAC_SO:
            begin
                mul_a = beta;
                mul_b = smooth_sin_reg;
            end
            default:
            begin
            end
        endcase
    end

    // shared blend multiplier and output angle rounding
    assign prod    = mul_a * mul_b;
    assign z_round = c_z_out + RND_OUT;

    hs_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .x_in    (cx),
        .y_in    (cy),
        .z_in    (cz),
        .done    (c_done),
        .z_out   (c_z_out),
        .cos_out (c_cos),
        .sin_out (c_sin)
    );

    // control state and smoothed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            alpha_reg      <= ALPHA_RESET;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            smooth_cos_reg <= SM_ONE;
            smooth_sin_reg <= '0;
            run_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                alpha_reg <= cfg_wr_data;
            if (accept)
            begin
                prev_x_reg <= pos_x;
                prev_y_reg <= pos_y;
                if (first_point)
                    run_valid_reg <= heading_valid;
            end
            if (state_reg == ST_SEED_WAIT && c_done)
            begin
                smooth_cos_reg <= c_cos;
                smooth_sin_reg <= c_sin;
            end
            if (state_reg == ST_MAC_SN)
                smooth_cos_reg <= sat_acc(acc_reg);
            if (state_reg == ST_MAC_END)
                smooth_sin_reg <= sat_acc(acc_reg);
            if (state_reg == ST_RESULT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request payload, accumulator and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg  <= DIFF_BITS'(pos_x) - DIFF_BITS'(prev_x_reg);
            dy_reg  <= DIFF_BITS'(pos_y) - DIFF_BITS'(prev_y_reg);
            ih_reg  <= start_heading;
            res_reg <= (first_point && heading_valid) ? start_heading : original_yaw;
        end
        if (state_reg == ST_ROT_WAIT && c_done)
        begin
            cn_reg <= c_cos;
            sn_reg <= c_sin;
        end
        case (state_reg)
            ST_MAC_CN, ST_MAC_SN: acc_reg <= ACC_BITS'(prod);
            ST_MAC_CO, ST_MAC_SO: acc_reg <= acc_reg + ACC_BITS'(prod) + RND_MAC;
            default:
            begin
            end
        endcase
        if (state_reg == ST_FIX_WAIT && c_done)
            res_reg <= z_round[ZW-1 -: ANGLE_BITS];
        if (state_reg == ST_RESULT && out_free)
            yaw_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign yaw       = yaw_reg;

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while still busy");

    a_fix_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX_WAIT) |-> run_valid_reg)
        else $error("smoothing outside a valid run");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free) |=> out_valid)
        else $error("result not presented");

endmodule

// File: hdl/hs_cordic.sv
// hs_cordic: shared cordic engine, one micro-rotation per cycle, vectoring
// (atan2 with operand normalization) and rotation (cos/sin); uses hs_pkg
module hs_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hs_pkg::cordic_cmd_t               cmd,
    input  logic signed [hs_pkg::CW-1:0]      x_in,
    input  logic signed [hs_pkg::CW-1:0]      y_in,
    input  logic signed [hs_pkg::ZW-1:0]      z_in,
    output logic                              done,
    output logic signed [hs_pkg::ZW-1:0]      z_out,
    output logic signed [hs_pkg::SM_BITS-1:0] cos_out,
    output logic signed [hs_pkg::SM_BITS-1:0] sin_out
);
    import hs_pkg::*;

    localparam logic [CW-1:0]        NORM_LO  = CW'(1) << 40;
    localparam logic [CW-1:0]        NORM_HI  = CW'(1) << 41;
    localparam logic [CW-1:0]        COARSE   = CW'(1) << 32;
    localparam logic signed [ZW:0]   QUARTER  = (ZW+1)'(1) << (ZW - 2);
    localparam logic signed [ZW:0]   HALF_T   = (ZW+1)'(1) << (ZW - 1);
    localparam logic signed [CW-1:0] RND_Q16  = CW'(8192);

    cordic_state_t         state_reg, state_next;
    cordic_mode_t          mode_reg, mode_next;
    logic signed [CW-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic [ITER_BITS-1:0]  iter_reg, iter_next;
    logic                  neg_reg, neg_next;

    logic [CW-1:0]         mag_x, mag_y, mag_m;
    logic signed [CW-1:0]  xs, ys, xf, yf, xr, yr;
    logic signed [ZW:0]    z_wide;
    logic                  in_zero, norm_ok, turn_up;

    // magnitude of the current vector
    always_comb
    begin
        mag_x   = x_reg[CW-1] ? CW'(-x_reg) : CW'(x_reg);
        mag_y   = y_reg[CW-1] ? CW'(-y_reg) : CW'(y_reg);
        mag_m   = (mag_x > mag_y) ? mag_x : mag_y;
        norm_ok = (mag_m >= NORM_LO) && (mag_m < NORM_HI);
        in_zero = (x_in == '0) && (y_in == '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.mode == MODE_ROTATE)
                        state_next = CS_ITER;
                    else if (in_zero)
                        state_next = CS_DONE;
                    else
                        state_next = CS_NORM;
                end
            end
            CS_NORM:
            begin
                if (norm_ok)
                    state_next = CS_ITER;
            end
            CS_ITER:
            begin
                if (iter_reg == ITER_BITS'(CORDIC_STEPS - 1))
                    state_next = CS_DONE;
            end
            CS_DONE:
                state_next = CS_IDLE;
            default:
                state_next = CS_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        mode_next = mode_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        neg_next  = neg_reg;
        xs        = x_reg >>> iter_reg;
        ys        = y_reg >>> iter_reg;
        z_wide    = {z_in[ZW-1], z_in};
        turn_up   = (mode_reg == MODE_VECTOR) ? !y_reg[CW-1] : z_reg[ZW-1];
        case (state_reg)
            CS_IDLE:
            begin
                if (cmd.start)
                begin
                    mode_next = cmd.mode;
                    iter_next = '0;
                    neg_next  = 1'b0;
                    if (cmd.mode == MODE_ROTATE)
                    begin
                        x_next = GAIN_Q30;
                        y_next = '0;
                        // fold into the right half plane by a half turn
                        if (z_wide > QUARTER)
                        begin
                            z_next   = ZW'(z_wide - HALF_T);
                            neg_next = 1'b1;
                        end
                        else if (z_wide < -QUARTER)
                        begin
                            z_next   = ZW'(z_wide + HALF_T);
                            neg_next = 1'b1;
                        end
                        else
                            z_next = z_in;
                    end
                    else
                    begin
                        x_next = x_in;
                        y_next = y_in;
                        z_next = '0;
                    end
                end
            end
            CS_NORM:
            begin
                if (mag_m >= NORM_HI)
                begin
                    x_next = x_reg >>> 1;
                    y_next = y_reg >>> 1;
                end
                else if (mag_m < COARSE)
                begin
                    x_next = x_reg <<< 8;
                    y_next = y_reg <<< 8;
                end
                else if (mag_m < NORM_LO)
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
                else if (x_reg[CW-1])
                begin
                    // left half plane: turn by a quarter first
                    if (!y_reg[CW-1])
                    begin
                        x_next = y_reg;
                        y_next = -x_reg;
                        z_next = ZW'(QUARTER);
                    end
                    else
                    begin
                        x_next = -y_reg;
                        y_next = x_reg;
                        z_next = ZW'(-QUARTER);
                    end
                end
            end
            CS_ITER:
            begin
                iter_next = iter_reg + 1'b1;
                if (turn_up)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_lookup(iter_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_lookup(iter_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        iter_reg <= iter_next;
        neg_reg  <= neg_next;
    end

    // outputs, q2.30 rounded to q1.16
    always_comb
    begin
        done    = (state_reg == CS_DONE);
        z_out   = z_reg;
        xf      = neg_reg ? -x_reg : x_reg;
        yf      = neg_reg ? -y_reg : y_reg;
        xr      = (xf + RND_Q16) >>> 14;
        yr      = (yf + RND_Q16) >>> 14;
        cos_out = xr[SM_BITS-1:0];
        sin_out = yr[SM_BITS-1:0];
    end

    // start only lands on an idle engine
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (state_reg == CS_IDLE))
        else $error("cordic started while busy");

    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_ITER) |-> (iter_reg < ITER_BITS'(CORDIC_STEPS)))
        else $error("cordic step count out of range");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("cordic done longer than one cycle");

endmodule
